@@ hw/rtl/dsuf_pkg.sv @@
package dsuf_pkg;

	localparam int NODE_W = 10;

	typedef struct packed {
		logic              mode;
		logic [NODE_W-1:0] first_node;
		logic [NODE_W-1:0] second_node;
	} dsuf_req_t;

	typedef struct packed {
		logic [NODE_W-1:0] root_node;
		logic              merged;
	} dsuf_rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_COMP,
		ST_LINK,
		ST_GRAFT,
		ST_RESULT
	} dsuf_state_t;

	localparam logic MODE_FIND = 1'b0;
	localparam logic MODE_JOIN = 1'b1;

endpackage

@@ hw/rtl/dsuf_ram.sv @@
module dsuf_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/disjoint_set_union_find_core.sv @@
// Disjoint-set store with union by size and path compression. Each request
// takes a find (mode 0) or a join (mode 1) and returns one response with the
// root and a merged flag. After reset the core sets every entry to a singleton
// set and holds req_stall high meanwhile. The table sits in one RAM with a
// single read and a single write port, and the core follows one parent link
// per cycle: a find walks up to the root, then walks the path again to
// compress it, and a join does this for both nodes, then links the root of
// the smaller set under the root of the larger one; when both nodes already
// share a root the link is skipped. Only one request is in flight; the next
// one is accepted while the previous response still waits.
module disjoint_set_union_find_core #(
	parameter int NODES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  dsuf_pkg::dsuf_req_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output dsuf_pkg::dsuf_rsp_t rsp
);

	localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int EW = $clog2(NODES + 1) + 1;

	dsuf_pkg::dsuf_state_t state_q, state_d;

	logic [IW-1:0]        clr_q, clr_d;
	logic                 phase_q, phase_d;
	logic                 mode_q, mode_d;
	logic [IW-1:0]        cur_q, cur_d;
	logic [IW-1:0]        start_q, start_d;
	logic [IW-1:0]        second_q, second_d;
	logic [IW-1:0]        root_q, root_d;
	logic signed [EW-1:0] size_q, size_d;
	logic [IW-1:0]        roota_q, roota_d;
	logic signed [EW-1:0] sizea_q, sizea_d;
	logic [IW-1:0]        keep_q, keep_d;
	logic [IW-1:0]        gone_q, gone_d;
	logic [IW-1:0]        res_root_q, res_root_d;
	logic                 res_merged_q, res_merged_d;
	logic                 rsp_valid_q, rsp_valid_d;
	dsuf_pkg::dsuf_rsp_t  rsp_q, rsp_d;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	logic [31:0]   first_ext, second_ext, res_ext;
	logic [IW-1:0] first_idx, second_idx;
	logic [IW-1:0] parent;
	logic          is_root;

	dsuf_ram #(
		.WIDTH(EW),
		.DEPTH(NODES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign first_ext  = 32'(req.first_node);
	assign second_ext = 32'(req.second_node);
	assign first_idx  = (first_ext > 32'(NODES - 1)) ? IW'(NODES - 1) : first_ext[IW-1:0];
	assign second_idx = (second_ext > 32'(NODES - 1)) ? IW'(NODES - 1) : second_ext[IW-1:0];
	assign parent     = ram_rdata[IW-1:0];
	assign is_root    = ram_rdata[EW-1];
	assign res_ext    = 32'(res_root_q);

	assign req_stall = (state_q != dsuf_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d      = state_q;
		clr_d        = clr_q;
		phase_d      = phase_q;
		mode_d       = mode_q;
		cur_d        = cur_q;
		start_d      = start_q;
		second_d     = second_q;
		root_d       = root_q;
		size_d       = size_q;
		roota_d      = roota_q;
		sizea_d      = sizea_q;
		keep_d       = keep_q;
		gone_d       = gone_q;
		res_root_d   = res_root_q;
		res_merged_d = res_merged_q;
		rsp_valid_d  = rsp_valid_q && rsp_stall;
		rsp_d        = rsp_q;
		ram_we       = 1'b0;
		ram_waddr    = cur_q;
		ram_wdata    = {EW{1'b1}};
		ram_raddr    = cur_q;
		case (state_q)
			dsuf_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = {EW{1'b1}};
				clr_d     = clr_q + 1'b1;
				if (32'(clr_q) == 32'(NODES - 1)) begin
					state_d = dsuf_pkg::ST_IDLE;
				end
			end
			dsuf_pkg::ST_IDLE: begin
				if (req_valid) begin
					ram_raddr = first_idx;
					cur_d     = first_idx;
					start_d   = first_idx;
					second_d  = second_idx;
					mode_d    = req.mode;
					phase_d   = 1'b0;
					state_d   = dsuf_pkg::ST_WALK;
				end
			end
			dsuf_pkg::ST_WALK: begin
				if (is_root) begin
					root_d    = cur_q;
					size_d    = $signed(ram_rdata);
					ram_raddr = start_q;
					cur_d     = start_q;
					state_d   = dsuf_pkg::ST_COMP;
				end else begin
					ram_raddr = parent;
					cur_d     = parent;
				end
			end
			dsuf_pkg::ST_COMP: begin
				if (is_root) begin
					if (!phase_q) begin
						roota_d = root_q;
						sizea_d = size_q;
						if (mode_q == dsuf_pkg::MODE_JOIN) begin
							phase_d   = 1'b1;
							ram_raddr = second_q;
							cur_d     = second_q;
							start_d   = second_q;
							state_d   = dsuf_pkg::ST_WALK;
						end else begin
							res_root_d   = root_q;
							res_merged_d = 1'b0;
							state_d      = dsuf_pkg::ST_RESULT;
						end
					end else if (roota_q == root_q) begin
						res_root_d   = root_q;
						res_merged_d = 1'b0;
						state_d      = dsuf_pkg::ST_RESULT;
					end else begin
						state_d = dsuf_pkg::ST_LINK;
					end
				end else begin
					ram_we    = 1'b1;
					ram_waddr = cur_q;
					ram_wdata = {{(EW - IW){1'b0}}, root_q};
					ram_raddr = parent;
					cur_d     = parent;
				end
			end
			dsuf_pkg::ST_LINK: begin
				if (sizea_q > size_q) begin
					keep_d = root_q;
					gone_d = roota_q;
				end else begin
					keep_d = roota_q;
					gone_d = root_q;
				end
				ram_we    = 1'b1;
				ram_waddr = (sizea_q > size_q) ? root_q : roota_q;
				ram_wdata = EW'(sizea_q + size_q);
				state_d   = dsuf_pkg::ST_GRAFT;
			end
			dsuf_pkg::ST_GRAFT: begin
				ram_we       = 1'b1;
				ram_waddr    = gone_q;
				ram_wdata    = {{(EW - IW){1'b0}}, keep_q};
				res_root_d   = keep_q;
				res_merged_d = 1'b1;
				state_d      = dsuf_pkg::ST_RESULT;
			end
			dsuf_pkg::ST_RESULT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_valid_d       = 1'b1;
					rsp_d.root_node   = res_ext[dsuf_pkg::NODE_W-1:0];
					rsp_d.merged      = res_merged_q;
					state_d           = dsuf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dsuf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dsuf_pkg::ST_CLEAR;
			clr_q       <= '0;
			phase_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			phase_q     <= phase_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q       <= mode_d;
		cur_q        <= cur_d;
		start_q      <= start_d;
		second_q     <= second_d;
		root_q       <= root_d;
		size_q       <= size_d;
		roota_q      <= roota_d;
		sizea_q      <= sizea_d;
		keep_q       <= keep_d;
		gone_q       <= gone_d;
		res_root_q   <= res_root_d;
		res_merged_q <= res_merged_d;
		rsp_q        <= rsp_d;
	end

	// Compression must never overwrite the size held by the root.
	a_comp_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dsuf_pkg::ST_COMP && ram_we) |-> (cur_q != root_q))
		else $error("compression wrote the root entry");

	a_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == dsuf_pkg::ST_WALK))
		else $error("accepted request did not start a walk");

	a_graft_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dsuf_pkg::ST_GRAFT) |-> (keep_q != gone_q))
		else $error("join linked a root to itself");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dsuf_pkg::ST_RESULT && rsp_valid_q && rsp_stall) |=>
		(state_q == dsuf_pkg::ST_RESULT))
		else $error("response register overwritten while stalled");

endmodule
